@@ rtl/ppf_pkg.sv @@
// package with record types, register indexes and fixed widths of the pulse peak finder
`timescale 1ns / 1ps

package ppf_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THR  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH = 2'd3;

    localparam int LEVEL_W = 16;
    localparam int THR_W   = 16;
    localparam int MINW_W  = 32;

    localparam logic signed [LEVEL_W-1:0] BASELINE_RST  = 16'sd0;
    localparam logic [THR_W-1:0]          THR_RST       = 16'd0;
    localparam logic [MINW_W-1:0]         MIN_WIDTH_RST = 32'd15;

    // result record fields
    localparam int KIND_W      = 2;
    localparam int OUT_NUM_W   = 16;
    localparam int OUT_TIME_W  = 32;
    localparam int OUT_VAL_W   = 16;
    localparam int OUT_WIDTH_W = 32;
    localparam int OUT_HGT_W   = 16;
    localparam int OUT_TDATA_W = OUT_NUM_W + OUT_TIME_W + OUT_VAL_W + OUT_WIDTH_W + OUT_HGT_W;

    localparam logic [OUT_HGT_W-1:0] HEIGHT_MAX = 16'hFFFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_PEAK    = 2'd0,
        KIND_NONE    = 2'd1,
        KIND_SUMMARY = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                         kind;
        logic [OUT_NUM_W-1:0]          peak_number;
        logic [OUT_TIME_W-1:0]         peak_time;
        logic signed [OUT_VAL_W-1:0]   peak_value;
        logic [OUT_WIDTH_W-1:0]        pulse_width;
        logic [OUT_HGT_W-1:0]          height;
        logic                          last;
    } t_rec;

    // up to two records caused by one sample, first in r0
    typedef struct packed {
        logic v0;
        logic v1;
        t_rec r0;
        t_rec r1;
    } t_res_pair;

    // output queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 3;

endpackage

@@ rtl/pulse_peak_finder_top.sv @@
// records pass through a four-entry queue, written as their sample is taken, offered in order
// throughput: one sample per cycle unless tready is low; records leave one per cycle when taken
// an end-of-waveform sample can make two records, so tready falls while the queue holds three
// or more records
// reset: synchronous active-low i_rst_n clears waveform state and queue, registers to defaults
`timescale 1ns / 1ps

module pulse_peak_finder_top #(
    parameter int SAMPLE_BITS = 16,
    parameter int TIME_BITS   = 32,
    parameter int COUNT_BITS  = 16,
    parameter int IN_TDATA_W  = ((SAMPLE_BITS + TIME_BITS + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [ppf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ppf_pkg::CFG_DATA_W-1:0]    i_cfg_wr_data,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // sample_value, sample_time
    input  logic [IN_TDATA_W-1:0]             i_s_tdata,
    // end_of_waveform
    input  logic                              i_s_tlast,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // peak_number, peak_time, peak_value, pulse_width, height above baseline
    output logic [ppf_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // record_kind
    output logic [ppf_pkg::KIND_W-1:0]        o_m_tuser,
    // last_of_run
    output logic                              o_m_tlast
);
    import ppf_pkg::*;

    logic      accept;
    t_res_pair res;
    t_rec      rec;

    assign accept = i_s_tvalid & o_s_tready;

    ppf_core #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_accept          (accept),
        .i_sample_value    ($signed(i_s_tdata[SAMPLE_BITS-1:0])),
        .i_sample_time     (i_s_tdata[SAMPLE_BITS +: TIME_BITS]),
        .i_end_of_waveform (i_s_tlast),
        .o_res             (res)
    );

    ppf_oq u_oq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_res       (res),
        .o_ready     (o_s_tready),
        .o_valid     (o_m_tvalid),
        .i_pop_ready (i_m_tready),
        .o_rec       (rec)
    );

    assign o_m_tdata = {rec.height, rec.pulse_width, rec.peak_value,
                        rec.peak_time, rec.peak_number};
    assign o_m_tuser = rec.kind;
    assign o_m_tlast = rec.last;

endmodule

@@ rtl/ppf_core.sv @@
// pulse detection core: configuration registers, per-waveform state and record forming
`timescale 1ns / 1ps

module ppf_core #(
    parameter int SAMPLE_BITS = 16,
    parameter int TIME_BITS   = 32,
    parameter int COUNT_BITS  = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [ppf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ppf_pkg::CFG_DATA_W-1:0]   i_cfg_wr_data,
    input  logic                             i_accept,
    input  logic signed [SAMPLE_BITS-1:0]    i_sample_value,
    input  logic [TIME_BITS-1:0]             i_sample_time,
    input  logic                             i_end_of_waveform,
    output ppf_pkg::t_res_pair               o_res
);
    import ppf_pkg::*;

    localparam int W     = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;
    localparam int DEV_W = W + 1;
    localparam int TW    = (TIME_BITS > MINW_W) ? TIME_BITS : MINW_W;

    function automatic logic [DEV_W-1:0] dev(input logic signed [W-1:0] v,
                                             input logic signed [LEVEL_W-1:0] base);
        logic signed [DEV_W-1:0] d;
        d = DEV_W'(v) - DEV_W'(base);
        return d[DEV_W-1] ? $unsigned(-d) : $unsigned(d);
    endfunction

    // configuration
    logic signed [LEVEL_W-1:0] r_baseline;
    logic [THR_W-1:0]          r_peak_thr;
    logic [THR_W-1:0]          r_edge_thr;
    logic [MINW_W-1:0]         r_min_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_baseline  <= BASELINE_RST;
            r_peak_thr  <= THR_RST;
            r_edge_thr  <= THR_RST;
            r_min_width <= MIN_WIDTH_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_BASELINE:  r_baseline  <= $signed(i_cfg_wr_data[LEVEL_W-1:0]);
                CFG_PEAK_THR:  r_peak_thr  <= i_cfg_wr_data[THR_W-1:0];
                CFG_EDGE_THR:  r_edge_thr  <= i_cfg_wr_data[THR_W-1:0];
                CFG_MIN_WIDTH: r_min_width <= i_cfg_wr_data[MINW_W-1:0];
                default: ;
            endcase
        end
    end

    // per-waveform state
    logic signed [SAMPLE_BITS-1:0] r_prev_value, n_prev_value;
    logic [TIME_BITS-1:0]          r_prev_time, n_prev_time;
    logic                          r_first, n_first;
    logic                          r_in_pulse, n_in_pulse;
    logic [TIME_BITS-1:0]          r_start, n_start;
    logic signed [W-1:0]           r_run_max, n_run_max;
    logic signed [SAMPLE_BITS-1:0] r_cap_val, n_cap_val;
    logic [TIME_BITS-1:0]          r_cap_time, n_cap_time;
    logic [TIME_BITS-1:0]          r_width, n_width;
    logic [OUT_HGT_W-1:0]          r_height, n_height;
    logic [COUNT_BITS-1:0]         r_count, n_count;
    logic                          r_any, n_any;

    logic signed [SAMPLE_BITS-1:0] ylag;
    logic [TIME_BITS-1:0]          xlag;
    logic [DEV_W-1:0]              dy, dlag, dmax, h_full;
    logic [DEV_W-1:0]              edge_thr, peak_thr;
    logic                          pulse_open, pulse_close, candidate, emit_peak;
    logic                          in_pulse_mid, any_mid;
    logic [TIME_BITS-1:0]          start_mid, cap_time_mid, width_raw, width_mid;
    logic signed [W-1:0]           run_max_mid;
    logic signed [SAMPLE_BITS-1:0] cap_val_mid;
    logic [OUT_HGT_W-1:0]          height_sat, height_mid;
    logic [COUNT_BITS-1:0]         count_mid;
    t_rec                          peak_rec, none_rec, sum_rec;

    always_comb begin
        // first sample of a waveform is its own predecessor
        ylag = r_first ? i_sample_value : r_prev_value;
        xlag = r_first ? i_sample_time  : r_prev_time;

        dy       = dev(W'(i_sample_value), r_baseline);
        dlag     = dev(W'(ylag), r_baseline);
        dmax     = dev(r_run_max, r_baseline);
        edge_thr = DEV_W'(r_edge_thr);
        peak_thr = DEV_W'(r_peak_thr);

        pulse_open   = (dlag < edge_thr) && !r_in_pulse && (dy > edge_thr);
        in_pulse_mid = r_in_pulse | pulse_open;
        start_mid    = pulse_open ? i_sample_time : r_start;

        candidate    = (dy > peak_thr) && (dlag > dmax);
        run_max_mid  = candidate ? W'(ylag) : r_run_max;
        cap_val_mid  = (candidate && (dy < dlag)) ? ylag : r_cap_val;
        cap_time_mid = (candidate && (dy < dlag)) ? xlag : r_cap_time;

        pulse_close = (dlag > edge_thr) && (dy < edge_thr) && in_pulse_mid;
        // time running backwards gives zero width
        width_raw   = (xlag >= start_mid) ? (xlag - start_mid) : '0;
        emit_peak   = pulse_close && (width_raw != '0) &&
                      (TW'(width_raw) > TW'(r_min_width)) && (cap_val_mid != '0);

        h_full     = dev(W'(cap_val_mid), r_baseline);
        height_sat = (h_full > DEV_W'(HEIGHT_MAX)) ? HEIGHT_MAX : h_full[OUT_HGT_W-1:0];

        width_mid  = pulse_close ? width_raw : r_width;
        height_mid = emit_peak ? height_sat : r_height;
        count_mid  = emit_peak ? (r_count + COUNT_BITS'(1)) : r_count;
        any_mid    = r_any | emit_peak;
    end

    always_comb begin
        peak_rec.kind        = KIND_PEAK;
        peak_rec.peak_number = OUT_NUM_W'(count_mid);
        peak_rec.peak_time   = OUT_TIME_W'(cap_time_mid);
        peak_rec.peak_value  = OUT_VAL_W'(cap_val_mid);
        peak_rec.pulse_width = OUT_WIDTH_W'(width_mid);
        peak_rec.height      = height_mid;
        peak_rec.last        = 1'b0;

        none_rec      = peak_rec;
        none_rec.kind = KIND_NONE;

        sum_rec.kind        = KIND_SUMMARY;
        sum_rec.peak_number = OUT_NUM_W'(count_mid);
        sum_rec.peak_time   = '0;
        sum_rec.peak_value  = '0;
        sum_rec.pulse_width = '0;
        sum_rec.height      = '0;
        sum_rec.last        = 1'b1;

        o_res.v0 = emit_peak | i_end_of_waveform;
        o_res.v1 = i_end_of_waveform & (emit_peak | !any_mid);
        if (emit_peak) begin
            o_res.r0 = peak_rec;
        end else if (!any_mid) begin
            o_res.r0 = none_rec;
        end else begin
            o_res.r0 = sum_rec;
        end
        o_res.r0.last = !o_res.v1;
        o_res.r1      = sum_rec;
    end

    always_comb begin
        n_prev_value = r_prev_value;
        n_prev_time  = r_prev_time;
        n_first      = r_first;
        n_in_pulse   = r_in_pulse;
        n_start      = r_start;
        n_run_max    = r_run_max;
        n_cap_val    = r_cap_val;
        n_cap_time   = r_cap_time;
        n_width      = r_width;
        n_height     = r_height;
        n_count      = r_count;
        n_any        = r_any;
        if (i_accept) begin
            if (i_end_of_waveform) begin
                n_prev_value = '0;
                n_prev_time  = '0;
                n_first      = 1'b1;
                n_in_pulse   = 1'b0;
                n_start      = '0;
                n_run_max    = W'(r_baseline);
                n_cap_val    = '0;
                n_cap_time   = '0;
                n_width      = '0;
                n_height     = '0;
                n_count      = '0;
                n_any        = 1'b0;
            end else begin
                n_prev_value = i_sample_value;
                n_prev_time  = i_sample_time;
                n_first      = 1'b0;
                n_in_pulse   = pulse_close ? 1'b0 : in_pulse_mid;
                n_start      = start_mid;
                n_run_max    = pulse_close ? W'(r_baseline) : run_max_mid;
                n_cap_val    = cap_val_mid;
                n_cap_time   = cap_time_mid;
                n_width      = width_mid;
                n_height     = height_mid;
                n_count      = count_mid;
                n_any        = any_mid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_value <= '0;
            r_prev_time  <= '0;
            r_first      <= 1'b1;
            r_in_pulse   <= 1'b0;
            r_start      <= '0;
            r_run_max    <= W'(BASELINE_RST);
            r_cap_val    <= '0;
            r_cap_time   <= '0;
            r_width      <= '0;
            r_height     <= '0;
            r_count      <= '0;
            r_any        <= 1'b0;
        end else begin
            r_prev_value <= n_prev_value;
            r_prev_time  <= n_prev_time;
            r_first      <= n_first;
            r_in_pulse   <= n_in_pulse;
            r_start      <= n_start;
            r_run_max    <= n_run_max;
            r_cap_val    <= n_cap_val;
            r_cap_time   <= n_cap_time;
            r_width      <= n_width;
            r_height     <= n_height;
            r_count      <= n_count;
            r_any        <= n_any;
        end
    end

endmodule

@@ rtl/ppf_oq.sv @@
// output record queue: takes up to two records a cycle, hands out one
`timescale 1ns / 1ps

module ppf_oq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ppf_pkg::t_res_pair i_res,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_pop_ready,
    output ppf_pkg::t_rec      o_rec
);
    import ppf_pkg::*;

    t_rec                r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [OQ_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [OQ_CNT_W-1:0] r_count, n_count;
    logic [OQ_CNT_W-1:0] push_n;
    logic                pop;

    always_comb begin
        push_n   = i_push ? (OQ_CNT_W'(i_res.v0) + OQ_CNT_W'(i_res.v1)) : '0;
        pop      = (r_count != '0) && i_pop_ready;
        n_wr_ptr = r_wr_ptr + OQ_PTR_W'(push_n);
        n_rd_ptr = r_rd_ptr + OQ_PTR_W'(pop);
        n_count  = r_count + push_n - OQ_CNT_W'(pop);
    end

    // room for the two records an end-of-waveform sample can make
    assign o_ready = r_count <= OQ_CNT_W'(OQ_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push && i_res.v0) begin
            r_mem[r_wr_ptr] <= i_res.r0;
        end
        if (i_push && i_res.v1) begin
            r_mem[r_wr_ptr + OQ_PTR_W'(1)] <= i_res.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ rtl/ppf_chk.sv @@
// port-level checker for the pulse peak finder and its bind
`timescale 1ns / 1ps

module ppf_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [ppf_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    input logic [ppf_pkg::KIND_W-1:0]        o_m_tuser,
    input logic                              o_m_tlast
);
    import ppf_pkg::*;

    // reset empties the queue: nothing offered, samples taken
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("queue not empty after reset");

    // a stalled record holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled record changed");

    // a summary closes the run and carries only the count
    a_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_SUMMARY) |->
            o_m_tlast && (o_m_tdata[OUT_TDATA_W-1:OUT_NUM_W] == '0))
        else $error("malformed summary record");

    // a record that is not last of its run is followed by the summary of that run
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=>
            o_m_tvalid && (o_m_tuser == KIND_SUMMARY))
        else $error("record without following summary");

endmodule

bind pulse_peak_finder_top ppf_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

@@ tb/pulse_peak_finder_top_tb.sv @@
// self-checking testbench of the pulse peak finder, with a record predictor and random stimulus
`timescale 1ns / 1ps

module pulse_peak_finder_top_tb;

    import ppf_pkg::*;

    localparam int SAMPLE_W = 16;
    localparam int STAMP_W  = 32;
    localparam int IN_W     = ((SAMPLE_W + STAMP_W + 7) / 8) * 8;
    localparam int HOLD_CYCLES = 200;

    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic [STAMP_W-1:0]         stamp;
        logic                       eow;
    } t_sample_item;

    // predicts the records of each accepted sample and checks the records that leave
    class peak_record_checker;
        logic signed [LEVEL_W-1:0]  baseline;
        int                         peak_thr;
        int                         edge_thr;
        logic [MINW_W-1:0]          min_width;

        logic signed [SAMPLE_W-1:0] prev_value;
        logic [STAMP_W-1:0]         prev_stamp;
        bit                         first_pending;
        bit                         in_pulse;
        logic [STAMP_W-1:0]         pulse_start;
        logic signed [SAMPLE_W-1:0] run_max;
        logic signed [SAMPLE_W-1:0] cap_value;
        logic [STAMP_W-1:0]         cap_stamp;
        logic [OUT_WIDTH_W-1:0]     last_width;
        logic [OUT_HGT_W-1:0]       last_height;
        logic [OUT_NUM_W-1:0]       peak_count;
        bit                         any_peak;

        t_rec records_due[$];
        int   mismatches;

        function new();
            baseline   = BASELINE_RST;
            peak_thr   = int'(THR_RST);
            edge_thr   = int'(THR_RST);
            min_width  = MIN_WIDTH_RST;
            mismatches = 0;
            clear_waveform();
        endfunction

        function void clear_waveform();
            prev_value    = '0;
            prev_stamp    = '0;
            first_pending = 1'b1;
            in_pulse      = 1'b0;
            pulse_start   = '0;
            run_max       = baseline;
            cap_value     = '0;
            cap_stamp     = '0;
            last_width    = '0;
            last_height   = '0;
            peak_count    = '0;
            any_peak      = 1'b0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_BASELINE:  baseline  = data[LEVEL_W-1:0];
                CFG_PEAK_THR:  peak_thr  = int'(data[THR_W-1:0]);
                CFG_EDGE_THR:  edge_thr  = int'(data[THR_W-1:0]);
                CFG_MIN_WIDTH: min_width = data[MINW_W-1:0];
                default: ;
            endcase
        endfunction

        function int level_dev(logic signed [SAMPLE_W-1:0] v);
            int d;
            d = int'(v) - int'(baseline);
            return (d < 0) ? -d : d;
        endfunction

        function void add_record(t_kind kind, logic [OUT_NUM_W-1:0] num,
                                 logic [OUT_TIME_W-1:0] stamp,
                                 logic signed [OUT_VAL_W-1:0] value,
                                 logic [OUT_WIDTH_W-1:0] width,
                                 logic [OUT_HGT_W-1:0] hgt);
            t_rec rec;
            rec.kind        = kind;
            rec.peak_number = num;
            rec.peak_time   = stamp;
            rec.peak_value  = value;
            rec.pulse_width = width;
            rec.height      = hgt;
            rec.last        = 1'b0;
            records_due.insert(records_due.size(), rec);
        endfunction

        function void note_sample(t_sample_item s);
            logic signed [SAMPLE_W-1:0] y_lag;
            logic [STAMP_W-1:0]         x_lag;
            logic [STAMP_W-1:0]         w;
            int dy;
            int dlag;
            int h;
            int n_new;

            y_lag = first_pending ? s.value : prev_value;
            x_lag = first_pending ? s.stamp : prev_stamp;
            dy    = level_dev(s.value);
            dlag  = level_dev(y_lag);
            n_new = 0;

            if (dlag < edge_thr && !in_pulse && dy > edge_thr) begin
                pulse_start = s.stamp;
                in_pulse    = 1'b1;
            end

            // the previous sample becomes the candidate once the signal turns down
            if (dy > peak_thr && dlag > level_dev(run_max)) begin
                run_max = y_lag;
                if (dy < dlag) begin
                    cap_value = y_lag;
                    cap_stamp = x_lag;
                end
            end

            if (dlag > edge_thr && dy < edge_thr && in_pulse) begin
                w = (x_lag >= pulse_start) ? x_lag - pulse_start : '0;
                last_width = w;
                if (w != 0 && w > min_width && cap_value != 0) begin
                    h = level_dev(cap_value);
                    last_height = (h > int'(HEIGHT_MAX)) ? HEIGHT_MAX : h[OUT_HGT_W-1:0];
                    peak_count = peak_count + 1'b1;
                    add_record(KIND_PEAK, peak_count, cap_stamp, cap_value,
                               last_width, last_height);
                    n_new++;
                    any_peak = 1'b1;
                end
                in_pulse = 1'b0;
                run_max  = baseline;
            end

            prev_value    = s.value;
            prev_stamp    = s.stamp;
            first_pending = 1'b0;

            if (s.eow) begin
                if (!any_peak) begin
                    add_record(KIND_NONE, peak_count, cap_stamp, cap_value,
                               last_width, last_height);
                    n_new++;
                end
                add_record(KIND_SUMMARY, peak_count, '0, '0, '0, '0);
                n_new++;
                clear_waveform();
            end

            if (n_new > 0)
                records_due[records_due.size()-1].last = 1'b1;
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                             $realtime, name, want, got);
            end
        endfunction

        function void check_record(logic [KIND_W-1:0] kind, logic [OUT_TDATA_W-1:0] data,
                                   logic last);
            t_rec want;
            if (records_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: record with none expected, kind %0d data 0x%0h",
                             $realtime, kind, data);
                return;
            end
            want = records_due.pop_front();
            cmp_field("record_kind", want.kind, kind);
            cmp_field("peak_number", want.peak_number, data[15:0]);
            cmp_field("peak_time",   want.peak_time,   data[47:16]);
            cmp_field("peak_value",  {16'b0, want.peak_value}, data[63:48]);
            cmp_field("pulse_width", want.pulse_width, data[95:64]);
            cmp_field("height",      want.height,      data[111:96]);
            cmp_field("last_of_run", want.last, last);
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_wr_data;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    logic [IN_W-1:0]         i_s_tdata;
    logic                    i_s_tlast;
    logic                    o_m_tvalid;
    logic                    i_m_tready;
    logic [OUT_TDATA_W-1:0]  o_m_tdata;
    logic [KIND_W-1:0]       o_m_tuser;
    logic                    o_m_tlast;

    peak_record_checker sb;
    t_sample_item       pending_q[$];
    bit                 stall_req;
    bit                 hold_active;

    // current register values, for shaping the waveforms
    int                 cur_base;
    int                 cur_pthr;
    int                 cur_ethr;

    pulse_peak_finder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tlast     (i_s_tlast),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser),
        .o_m_tlast     (o_m_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int idle_len();
        if ($urandom_range(99) < 88)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] fit_sample(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    task automatic push_sample(int value, logic [STAMP_W-1:0] stamp, bit eow);
        t_sample_item s;
        s.value = 16'(value);
        s.stamp = stamp;
        s.eow   = eow;
        pending_q.insert(pending_q.size(), s);
    endtask

    // leaves the write enable high, set_regs lowers it after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_idx     <= idx;
        i_cfg_wr_data <= data;
        @(negedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic set_regs(int base, int pthr, int ethr, logic [MINW_W-1:0] minw);
        write_reg(CFG_BASELINE, 32'(base));
        write_reg(CFG_PEAK_THR, 32'(pthr));
        write_reg(CFG_EDGE_THR, 32'(ethr));
        write_reg(CFG_MIN_WIDTH, minw);
        i_cfg_wr_en <= 1'b0;
        cur_base = base;
        cur_pthr = pthr;
        cur_ethr = ethr;
    endtask

    // quiet stretches around baseline with triangular pulses, some noise and odd timestamps
    task automatic gen_waveforms(int n_items);
        t_sample_item s;
        int made;
        int wf_len;
        int k;
        int pulse_len;
        int pulse_left;
        int peak_pos;
        int idx;
        int sgn;
        int r;
        longint lo;
        longint hi;
        longint d;
        longint v;
        logic [STAMP_W-1:0] stamp;

        made = 0;
        while (made < n_items) begin
            wf_len     = $urandom_range(4, 60);
            stamp      = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(1000);
            sgn        = ($urandom_range(1) == 1) ? 1 : -1;
            pulse_left = 0;
            pulse_len  = 1;
            peak_pos   = 0;
            lo         = 0;
            hi         = 0;
            k          = 0;
            while (k < wf_len && made < n_items) begin
                if (pulse_left == 0 && $urandom_range(99) < 15) begin
                    pulse_len  = $urandom_range(2, 24);
                    pulse_left = pulse_len;
                    peak_pos   = $urandom_range(0, pulse_len - 1);
                    lo = cur_ethr + 1;
                    if (lo > 65535)
                        lo = 65535;
                    hi = cur_pthr + 1 + $urandom_range(0, 20000);
                    if (hi > 65535)
                        hi = 65535;
                    if (hi < lo)
                        hi = lo;
                    if ($urandom_range(9) == 0)
                        sgn = -sgn;
                end
                r = $urandom_range(99);
                if (pulse_left > 0) begin
                    idx = pulse_len - pulse_left;
                    if (idx <= peak_pos)
                        d = lo + (hi - lo) * (idx + 1) / (peak_pos + 1);
                    else
                        d = lo + (hi - lo) * (pulse_len - idx) / (pulse_len - peak_pos);
                    d = d + $urandom_range(0, 20) - 10;
                    pulse_left--;
                end else if (r < 8) begin
                    d = cur_ethr;
                end else if (r < 12) begin
                    d = cur_pthr;
                end else begin
                    d = $urandom_range(0, (cur_ethr / 2) + 8);
                end
                if (d < 0)
                    d = 0;
                v = longint'(cur_base) + sgn * d;
                if (v > 32767 || v < -32768)
                    v = longint'(cur_base) - sgn * d;
                s.value = fit_sample(v);
                if (pulse_left == 0 && r >= 94)
                    s.value = 16'($urandom());
                s.stamp = stamp;
                s.eow   = (k == wf_len - 1);
                pending_q.insert(pending_q.size(), s);

                r = $urandom_range(99);
                if (r < 85)
                    stamp = stamp + $urandom_range(1, 4);
                else if (r < 91)
                    stamp = stamp;
                else if (r < 96)
                    stamp = stamp + $urandom_range(1, 100000);
                else
                    stamp = stamp - $urandom_range(1, 50);
                k++;
                made++;
            end
        end
    endtask

    task automatic drive_queue();
        t_sample_item s;
        int gap;
        int calm_left;

        calm_left = 0;
        while (pending_q.size() > 0) begin
            s = pending_q.pop_front();
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= {s.stamp, s.value};
            i_s_tlast  <= s.eow;
            do @(posedge i_clk); while (!o_s_tready);
            sb.note_sample(s);
            @(negedge i_clk);
            gap = 0;
            if (calm_left > 0)
                calm_left--;
            else if (!hold_active && $urandom_range(99) < 4)
                calm_left = $urandom_range(30, 100);
            else if (!hold_active && $urandom_range(99) < 30)
                gap = idle_len();
            if (gap > 0 && pending_q.size() > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_s_tvalid <= 1'b0;
    endtask

    // block is idle once every record has left and the last samples have drained
    task automatic wait_idle();
        while (sb.records_due.size() > 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic run_phase(int base, int pthr, int ethr, logic [MINW_W-1:0] minw,
                             int n_items, bit stall);
        wait_idle();
        set_regs(base, pthr, ethr, minw);
        gen_waveforms(n_items);
        if (stall)
            stall_req = 1'b1;
        drive_queue();
    endtask

    // receiver: random tready, with one long hold-off on request
    initial begin : rx_proc
        int low_left;
        int calm_left;
        int hold_left;

        low_left  = 0;
        calm_left = 0;
        hold_left = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                if (hold_left == 0)
                    hold_active = 1'b0;
                i_m_tready <= 1'b0;
            end else if (stall_req) begin
                stall_req   = 1'b0;
                hold_active = 1'b1;
                hold_left   = HOLD_CYCLES;
                i_m_tready <= 1'b0;
            end else if (low_left > 0) begin
                low_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(99) < 3)
                    calm_left = $urandom_range(40, 150);
                else if ($urandom_range(99) < 30)
                    low_left = idle_len();
            end
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready)
                sb.check_record(o_m_tuser, o_m_tdata, o_m_tlast);
        end
    end

    initial begin
        #4000000;
        $display("** pulse_peak_finder_top: FAILED **");
        $finish;
    end

    initial begin
        sb            = new();
        stall_req     = 1'b0;
        hold_active   = 1'b0;
        cur_base      = int'(BASELINE_RST);
        cur_pthr      = int'(THR_RST);
        cur_ethr      = int'(THR_RST);
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_idx     = CFG_BASELINE;
        i_cfg_wr_data = '0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_s_tlast     = 1'b0;
        i_m_tready    = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // register defaults after reset
        gen_waveforms(60);
        drive_queue();

        // directed samples
        wait_idle();
        set_regs(0, 1000, 400, 32'd3);
        push_sample(0, 32'd0, 1'b0);
        // pulse with samples on both thresholds, closes into a peak record
        push_sample(500, 32'd10, 1'b0);
        push_sample(1000, 32'd12, 1'b0);
        push_sample(1500, 32'd13, 1'b0);
        push_sample(32767, 32'd14, 1'b0);
        push_sample(2000, 32'd16, 1'b0);
        push_sample(400, 32'd18, 1'b0);
        push_sample(100, 32'd20, 1'b0);
        push_sample(900, 32'd22, 1'b0);
        push_sample(0, 32'd24, 1'b0);
        // timestamps running backwards: zero width, no record
        push_sample(600, 32'd100, 1'b0);
        push_sample(2000, 32'd50, 1'b0);
        push_sample(3000, 32'd40, 1'b0);
        push_sample(1500, 32'd30, 1'b0);
        push_sample(0, 32'd20, 1'b0);
        // pulse without its own capture reuses the old one
        push_sample(700, 32'd200, 1'b0);
        push_sample(800, 32'd210, 1'b0);
        push_sample(0, 32'd220, 1'b0);
        // negative extreme, closed by the end-of-waveform sample
        push_sample(-32768, 32'hAAAA_5555, 1'b0);
        push_sample(-5000, 32'hAAAA_555B, 1'b0);
        push_sample(0, 32'hAAAA_555F, 1'b1);
        // waveforms without any peak
        push_sample(32767, 32'hFFFF_FFFF, 1'b0);
        push_sample(0, 32'd0, 1'b1);
        push_sample(-1, 32'h5555_AAAA, 1'b1);
        drive_queue();

        run_phase(200, 3000, 1000, 32'd10, 250, 1'b1);
        run_phase(-32768, 40000, 20000, 32'd0, 150, 1'b0);
        run_phase(32767, 65535, 65535, 32'hFFFF_FFFF, 60, 1'b0);
        run_phase(-500, 0, 0, 32'd0, 120, 1'b0);
        run_phase(1234, 800, 300, 32'd20, 110, 1'b0);

        wait_idle();
        if (sb.records_due.size() > 0) begin
            sb.mismatches++;
            $display("%0d expected records never arrived", sb.records_due.size());
        end
        if (sb.mismatches == 0)
            $display("** pulse_peak_finder_top: PASSED **");
        else
            $display("** pulse_peak_finder_top: FAILED **");
        $finish;
    end

endmodule
